// ===== hw/rtl/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Types and constants shared by the mu-law encode and pack block.
// ----------------------------------------------------------------------------
package mep_pkg;

   typedef logic signed [15:0] sample_type;
   typedef logic [13:0]        mag_type;
   typedef logic [6:0]         code_type;
   typedef logic [7:0]         mulaw_type;
   typedef logic [15:0]        word_type;

   // upper bound of each segment of the shifted magnitude
   localparam int unsigned SEG_COUNT = 9;
   localparam mag_type SEG_BP [SEG_COUNT] = '{
      14'd1, 14'd31, 14'd95, 14'd223, 14'd479,
      14'd991, 14'd2015, 14'd4063, 14'd7903
   };

   localparam code_type  CODE_MAX   = 7'd127;
   localparam mulaw_type INV_NEG    = 8'd127;
   localparam mulaw_type INV_POS    = 8'd255;
   localparam word_type  LOW_MASK   = 16'h00FF;
   localparam word_type  HIGH_MASK  = 16'hFF00;

endpackage

// ===== hw/rtl/mep_if.sv =====
// ----------------------------------------------------------------------------
// mep_req_if / mep_rsp_if
// Valid/ready channels for PCM samples in and packed mu-law words out.
// ----------------------------------------------------------------------------
interface mep_req_if import mep_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type pcm_sample;
   logic       last_sample;

   modport source (output valid, output pcm_sample, output last_sample, input ready);
   modport sink   (input valid, input pcm_sample, input last_sample, output ready);
endinterface

interface mep_rsp_if import mep_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type packed_word;
   logic     last_word;

   modport source (output valid, output packed_word, output last_word, input ready);
   modport sink   (input valid, input packed_word, input last_word, output ready);
endinterface

// ===== hw/rtl/mep_encoder.sv =====
// ----------------------------------------------------------------------------
// mep_encoder
// Linear PCM sample to mu-law byte, pure combinational segment search.
// ----------------------------------------------------------------------------
module mep_encoder import mep_pkg::*; (
   input  sample_type sample,
   output mulaw_type  mulaw
);

   logic signed [13:0] shifted;
   logic               neg;
   mag_type            mag;
   mag_type            diff;
   code_type           code;

   assign shifted = 14'(sample >>> 2);
   assign neg     = sample[15];
   // two's complement negate; -8192 maps to 8192 which fits unsigned
   assign mag     = neg ? mag_type'(~shifted + 14'sd1) : mag_type'(shifted);

   always_comb begin
      diff = '0;
      code = CODE_MAX;
      if (mag <= SEG_BP[0]) begin
         code = code_type'(mag);
      end else if (mag <= SEG_BP[1]) begin
         diff = mag - SEG_BP[0];
         code = code_type'(diff >> 1) + 7'd1;
      end else if (mag <= SEG_BP[2]) begin
         diff = mag - SEG_BP[1];
         code = code_type'(diff >> 2) + 7'd16;
      end else if (mag <= SEG_BP[3]) begin
         diff = mag - SEG_BP[2];
         code = code_type'(diff >> 3) + 7'd32;
      end else if (mag <= SEG_BP[4]) begin
         diff = mag - SEG_BP[3];
         code = code_type'(diff >> 4) + 7'd48;
      end else if (mag <= SEG_BP[5]) begin
         diff = mag - SEG_BP[4];
         code = code_type'(diff >> 5) + 7'd64;
      end else if (mag <= SEG_BP[6]) begin
         diff = mag - SEG_BP[5];
         code = code_type'(diff >> 6) + 7'd80;
      end else if (mag <= SEG_BP[7]) begin
         diff = mag - SEG_BP[6];
         code = code_type'(diff >> 7) + 7'd96;
      end else if (mag <= SEG_BP[8]) begin
         diff = mag - SEG_BP[7];
         code = code_type'(diff >> 8) + 7'd112;
      end
   end

   assign mulaw = neg ? (INV_NEG - {1'b0, code}) : (INV_POS - {1'b0, code});

endmodule

// ===== hw/rtl/mep_packer.sv =====
// ----------------------------------------------------------------------------
// mep_packer
// Pairs mu-law bytes into 16-bit words (a final unpaired byte fills the low byte) and holds the output register.
// ----------------------------------------------------------------------------
module mep_packer import mep_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  mulaw_type  in_byte,
   input  logic       in_last,
   output logic       in_ready,
   mep_rsp_if.source  rsp
);

   logic      high_phase_ff, high_phase_in;
   mulaw_type held_ff, held_in;
   logic      out_valid_ff, out_valid_in;
   word_type  word_ff, word_in;
   logic      last_ff, last_in;
   logic      emits;
   logic      take;

   assign emits    = high_phase_ff || in_last;
   // a byte that only gets held never waits on the output side
   assign in_ready = !emits || !out_valid_ff || rsp.ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      high_phase_in = high_phase_ff;
      held_in       = held_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      word_in       = word_ff;
      last_in       = last_ff;
      if (take) begin
         if (high_phase_ff) begin
            word_in       = (word_type'(held_ff) & LOW_MASK)
                            | ((word_type'(in_byte) << 8) & HIGH_MASK);
            last_in       = in_last;
            out_valid_in  = 1'b1;
            high_phase_in = 1'b0;
            held_in       = '0;
         end else if (in_last) begin
            word_in      = word_type'(in_byte) & LOW_MASK;
            last_in      = 1'b1;
            out_valid_in = 1'b1;
            held_in      = '0;
         end else begin
            held_in       = in_byte;
            high_phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_phase_ff <= 1'b0;
         held_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         high_phase_ff <= high_phase_in;
         held_ff       <= held_in;
         out_valid_ff  <= out_valid_in;
      end
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.packed_word = word_ff;
   assign rsp.last_word   = last_ff;

endmodule

// ===== hw/rtl/mulaw_encode_pack_top.sv =====
// ----------------------------------------------------------------------------
// mulaw_encode_pack_top
// Mu-law encoder with two-byte packing, one sample per cycle while rsp_ch is not stalled.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          transfer when
//  req_ch   in   pcm_sample[15:0], last_sample    valid && ready
//  rsp_ch   out  packed_word[15:0], last_word     valid && ready
//
//  One sample per cycle sustained while rsp_ch is not stalled; a sample is
//  registered, encoded and packed into the output register.
//  Synchronous active-high reset clears the valid flags, packing phase and held byte.
//  A stall on rsp_ch only holds the input register when the waiting sample
//  would produce a word; held low bytes keep flowing.
// ----------------------------------------------------------------------------
module mulaw_encode_pack_top import mep_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mep_req_if.sink   req_ch,
   mep_rsp_if.source rsp_ch
);

   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_sample_ff;
   logic       s1_last_ff;
   mulaw_type  enc_byte;
   logic       pk_ready;
   logic       req_take;

   assign req_ch.ready = !s1_valid_ff || pk_ready;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !pk_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_sample_ff <= req_ch.pcm_sample;
         s1_last_ff   <= req_ch.last_sample;
      end
   end

   mep_encoder u_encoder (
      .sample (s1_sample_ff),
      .mulaw  (enc_byte)
   );

   mep_packer u_packer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_byte  (enc_byte),
      .in_last  (s1_last_ff),
      .in_ready (pk_ready),
      .rsp      (rsp_ch)
   );

endmodule
